[sv/b2s_pkg.sv]
`default_nettype none
package b2s_pkg;

  typedef logic [31:0] word_t;

  localparam logic [31:0] IV0 = 32'h6A09E667;
  localparam logic [31:0] IV1 = 32'hBB67AE85;
  localparam logic [31:0] IV2 = 32'h3C6EF372;
  localparam logic [31:0] IV3 = 32'hA54FF53A;
  localparam logic [31:0] IV4 = 32'h510E527F;
  localparam logic [31:0] IV5 = 32'h9B05688C;
  localparam logic [31:0] IV6 = 32'h1F83D9AB;
  localparam logic [31:0] IV7 = 32'h5BE0CD19;
  localparam logic [31:0] PARAM_WORD = 32'h01010000;
  localparam logic [31:0] DIGEST_BYTES = 32'd32;

  typedef struct packed {
    logic start_msg;
    logic absorb;
    logic pad_final;
    logic comp_start;
    logic comp_final;
    logic comp_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic buf_full;
    logic key_on;
    logic split;
    logic comp_done;
  } sts_t;

  function automatic word_t iv_word(input logic [2:0] i);
    word_t w;
    unique case (i)
      3'd0: w = IV0;
      3'd1: w = IV1;
      3'd2: w = IV2;
      3'd3: w = IV3;
      3'd4: w = IV4;
      3'd5: w = IV5;
      3'd6: w = IV6;
      default: w = IV7;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] k);
    logic [63:0] row;
    unique case (r)
      4'd0: row = 64'hFEDCBA9876543210;
      4'd1: row = 64'h357B20C16DF984AE;
      4'd2: row = 64'h491763EADF250C8B;
      4'd3: row = 64'h8F04A562EBCD1397;
      4'd4: row = 64'hD386CB1EFA427509;
      4'd5: row = 64'h91EF57D438B0A6C2;
      4'd6: row = 64'hB8293670A4DEF15C;
      4'd7: row = 64'hA2684F05931CE7BD;
      4'd8: row = 64'h5A417D2C803B9EF6;
      default: row = 64'h0DC3E9BF5167482A;
    endcase
    return row[{k, 2'b00} +: 4];
  endfunction

  function automatic logic [127:0] gmix(input word_t a, input word_t b, input word_t c,
                                        input word_t d, input word_t x, input word_t y);
    word_t a1, b1, c1, d1;
    a1 = a + b + x;
    d1 = d ^ a1; d1 = {d1[15:0], d1[31:16]};
    c1 = c + d1;
    b1 = b ^ c1; b1 = {b1[11:0], b1[31:12]};
    a1 = a1 + b1 + y;
    d1 = d1 ^ a1; d1 = {d1[7:0], d1[31:8]};
    c1 = c1 + d1;
    b1 = b1 ^ c1; b1 = {b1[6:0], b1[31:7]};
    return {a1, b1, c1, d1};
  endfunction

endpackage
`default_nettype wire

[sv/blake2s_256_hash_engine_top.sv]
// A word that fits in the block is taken without a stall; a keyed message start first loads the key
// block, and a word that straddles a block boundary is absorbed in part before the compression.
// A nonempty word that meets a full block waits for a start step and the compression half-rounds.
// A last word adds a pad and final start, the half-rounds and an output load, then 8 digest words.
// No input word is taken while a 16-word block is being compressed.
// Reset (rst_n, synchronous, active low) clears control state and key registers.
`default_nettype none
module blake2s_256_hash_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // data_word[31:0], byte_count[34:32], zero pad
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata, // digest_word[31:0]
  output logic [2:0]       out_tuser, // word_index[2:0]
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  localparam logic [2:0] REG_KEYLEN = 3'd0;
  localparam logic [2:0] REG_KEY0 = 3'd1;
  localparam logic [2:0] REG_KEY1 = 3'd2;
  localparam logic [2:0] REG_KEY2 = 3'd3;
  localparam logic [2:0] REG_KEY3 = 3'd4;

  b2s_pkg::cmd_t cmd;
  b2s_pkg::sts_t sts;
  logic [5:0] key_len_r;
  logic [255:0] key_r;
  logic [255:0] digest;
  logic [255:0] obuf_r;
  logic [2:0] oidx_r;
  logic ovalid_r;
  logic out_busy;
  logic ctrl_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= '0;
      key_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEYLEN: key_len_r <= cfg_data[5:0];
        REG_KEY0: key_r[63:0] <= cfg_data;
        REG_KEY1: key_r[127:64] <= cfg_data;
        REG_KEY2: key_r[191:128] <= cfg_data;
        REG_KEY3: key_r[255:192] <= cfg_data;
        default: ;
      endcase
    end
  end

  b2s_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(ctrl_ready),
    .item_last(in_tlast), .item_nonempty(in_tdata[34:32] != 3'd0),
    .sts(sts), .cmd(cmd), .out_busy(out_busy), .out_free(!ovalid_r)
  );

  assign in_tready = ctrl_ready;

  b2s_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .data_word(in_tdata[31:0]),
    .byte_count(in_tdata[34:32]), .key_len(key_len_r), .key(key_r), .digest(digest)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      oidx_r <= '0;
    end else if (out_busy && !ovalid_r) begin
      ovalid_r <= 1'b1;
      oidx_r <= '0;
      obuf_r <= digest;
    end else if (ovalid_r && out_tready) begin
      oidx_r <= oidx_r + 3'd1;
      if (oidx_r == 3'd7) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = obuf_r[oidx_r*32 +: 32];
  assign out_tuser = oidx_r;
  assign out_tlast = (oidx_r == 3'd7);

  wire unused_in = |in_tdata[39:35];
endmodule
`default_nettype wire

[sv/b2s_ctrl.sv]
`default_nettype none
module b2s_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic         item_last,
  input  wire logic         item_nonempty,
  input  wire b2s_pkg::sts_t sts,
  output b2s_pkg::cmd_t     cmd,
  output logic              out_busy,
  input  wire logic         out_free
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [2:0] state_r, state_nxt;
  logic in_msg_r, in_msg_nxt;
  logic final_r, final_nxt;
  logic acc;
  logic full;

  // A keyed message starts with the key block already full.
  assign full = sts.buf_full || (!in_msg_r && sts.key_on);
  assign in_tready = (state_r == S_IDLE) && !(item_nonempty && full) && !sts.split;
  assign acc = in_tvalid && in_tready;
  assign out_busy = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    in_msg_nxt = in_msg_r;
    final_nxt = final_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start_msg = !in_msg_r;
          in_msg_nxt = 1'b1;
          if (item_nonempty && full) begin
            if (in_msg_r) begin
              cmd.comp_start = 1'b1;
              state_nxt = S_COMP;
              final_nxt = 1'b0;
            end
          end else begin
            cmd.absorb = 1'b1;
            if (acc && item_last) begin
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_COMP: begin
        cmd.comp_step = 1'b1;
        if (sts.comp_done) begin
          state_nxt = final_r ? S_OUT : S_IDLE;
          if (final_r) begin
            cmd.finish = 1'b1;
            in_msg_nxt = 1'b0;
          end
        end
      end
      S_FIN: begin
        cmd.pad_final = 1'b1;
        cmd.comp_start = 1'b1;
        cmd.comp_final = 1'b1;
        final_nxt = 1'b1;
        state_nxt = S_COMP;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      in_msg_r <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      in_msg_r <= in_msg_nxt;
      final_r <= final_nxt;
    end
  end

`ifndef SYNTH
  a_comp_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.comp_start && !cmd.comp_final |-> state_r == S_IDLE && !in_tready)
    else $error("compression start outside idle");
  a_fin_to_comp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> state_r == S_COMP)
    else $error("final pad not followed by compression");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready)
    else $error("input ready while busy");
`endif
endmodule
`default_nettype wire

[sv/b2s_dp.sv]
`default_nettype none
module b2s_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire b2s_pkg::cmd_t cmd,
  output b2s_pkg::sts_t      sts,
  input  wire logic [31:0]   data_word,
  input  wire logic [2:0]    byte_count,
  input  wire logic [5:0]    key_len,
  input  wire logic [255:0]  key,
  output logic [255:0]       digest
);
  b2s_pkg::word_t h_r [8];
  b2s_pkg::word_t m_r [16];
  b2s_pkg::word_t v_r [16];
  logic [63:0] cnt_r;
  logic [6:0]  nbuf_r;
  logic [2:0]  skip_r;
  logic [4:0]  step_r;
  logic [5:0]  kl;
  logic [2:0]  n;
  logic [127:0] g0, g1, g2, g3;
  logic [3:0]  rnd;
  logic        diag;

  assign kl = (key_len > 6'd32) ? 6'd32 : key_len;
  assign n = (byte_count > 3'd4) ? 3'd4 : byte_count;
  assign rnd = step_r[4:1];
  assign diag = step_r[0];

  // A word splits when its remaining bytes do not fit in the block.
  always_comb begin
    sts.buf_full = (nbuf_r == 7'd64);
    sts.key_on = (kl != 6'd0);
    sts.split = ({1'b0, nbuf_r} + {5'd0, n}) > (8'd64 + {5'd0, skip_r});
    sts.comp_done = (step_r == 5'd19);
  end

  always_comb begin
    if (!diag) begin
      g0 = b2s_pkg::gmix(v_r[0], v_r[4], v_r[8],  v_r[12],
                         m_r[b2s_pkg::sigma(rnd, 4'd0)], m_r[b2s_pkg::sigma(rnd, 4'd1)]);
      g1 = b2s_pkg::gmix(v_r[1], v_r[5], v_r[9],  v_r[13],
                         m_r[b2s_pkg::sigma(rnd, 4'd2)], m_r[b2s_pkg::sigma(rnd, 4'd3)]);
      g2 = b2s_pkg::gmix(v_r[2], v_r[6], v_r[10], v_r[14],
                         m_r[b2s_pkg::sigma(rnd, 4'd4)], m_r[b2s_pkg::sigma(rnd, 4'd5)]);
      g3 = b2s_pkg::gmix(v_r[3], v_r[7], v_r[11], v_r[15],
                         m_r[b2s_pkg::sigma(rnd, 4'd6)], m_r[b2s_pkg::sigma(rnd, 4'd7)]);
    end else begin
      g0 = b2s_pkg::gmix(v_r[0], v_r[5], v_r[10], v_r[15],
                         m_r[b2s_pkg::sigma(rnd, 4'd8)], m_r[b2s_pkg::sigma(rnd, 4'd9)]);
      g1 = b2s_pkg::gmix(v_r[1], v_r[6], v_r[11], v_r[12],
                         m_r[b2s_pkg::sigma(rnd, 4'd10)], m_r[b2s_pkg::sigma(rnd, 4'd11)]);
      g2 = b2s_pkg::gmix(v_r[2], v_r[7], v_r[8],  v_r[13],
                         m_r[b2s_pkg::sigma(rnd, 4'd12)], m_r[b2s_pkg::sigma(rnd, 4'd13)]);
      g3 = b2s_pkg::gmix(v_r[3], v_r[4], v_r[9],  v_r[14],
                         m_r[b2s_pkg::sigma(rnd, 4'd14)], m_r[b2s_pkg::sigma(rnd, 4'd15)]);
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      digest[i*32 +: 32] = h_r[i];
    end
  end

  always_ff @(posedge clk) begin
    logic [6:0] pos;
    logic [6:0] base;
    logic [6:0] room;
    if (!rst_n) begin
      cnt_r <= '0;
      nbuf_r <= '0;
      skip_r <= '0;
      step_r <= '0;
    end else begin
      base = nbuf_r;
      if (cmd.start_msg) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= b2s_pkg::iv_word(3'(i));
        end
        h_r[0] <= b2s_pkg::IV0 ^ b2s_pkg::PARAM_WORD ^ {18'd0, kl, 8'd0} ^
                  b2s_pkg::DIGEST_BYTES;
        cnt_r <= '0;
        base = 7'd0;
        if (kl != 6'd0) begin
          for (int i = 0; i < 8; i++) begin
            for (int b = 0; b < 4; b++) begin
              m_r[i][b*8 +: 8] <= ((i*4 + b) < kl) ? key[(i*4+b)*8 +: 8] : 8'd0;
            end
          end
          for (int i = 8; i < 16; i++) begin
            m_r[i] <= '0;
          end
          base = 7'd64;
        end
        nbuf_r <= base;
      end
      if (cmd.absorb) begin
        for (int b = 0; b < 4; b++) begin
          pos = base + 7'(b) - {4'd0, skip_r};
          if (3'(b) < n && 3'(b) >= skip_r && !pos[6]) begin
            m_r[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= data_word[b*8 +: 8];
          end
        end
        if (sts.split) begin
          room = 7'd64 - base;
          nbuf_r <= 7'd64;
          skip_r <= skip_r + room[2:0];
        end else begin
          nbuf_r <= base + {4'd0, n} - {4'd0, skip_r};
          skip_r <= '0;
        end
      end
      if (cmd.pad_final) begin
        for (int i = 0; i < 64; i++) begin
          if (7'(i) >= nbuf_r) begin
            m_r[i/4][(i%4)*8 +: 8] <= 8'd0;
          end
        end
      end
      if (cmd.comp_start) begin
        logic [63:0] c;
        c = cmd.comp_final ? cnt_r + {57'd0, nbuf_r} : cnt_r + 64'd64;
        cnt_r <= c;
        for (int i = 0; i < 8; i++) begin
          v_r[i] <= h_r[i];
          v_r[8+i] <= b2s_pkg::iv_word(3'(i));
        end
        v_r[12] <= b2s_pkg::IV4 ^ c[31:0];
        v_r[13] <= b2s_pkg::IV5 ^ c[63:32];
        v_r[14] <= cmd.comp_final ? ~b2s_pkg::IV6 : b2s_pkg::IV6;
        if (!cmd.comp_final) begin
          nbuf_r <= 7'd0;
        end
        step_r <= '0;
      end
      if (cmd.comp_step) begin
        if (!diag) begin
          {v_r[0], v_r[4], v_r[8],  v_r[12]} <= g0;
          {v_r[1], v_r[5], v_r[9],  v_r[13]} <= g1;
          {v_r[2], v_r[6], v_r[10], v_r[14]} <= g2;
          {v_r[3], v_r[7], v_r[11], v_r[15]} <= g3;
        end else begin
          {v_r[0], v_r[5], v_r[10], v_r[15]} <= g0;
          {v_r[1], v_r[6], v_r[11], v_r[12]} <= g1;
          {v_r[2], v_r[7], v_r[8],  v_r[13]} <= g2;
          {v_r[3], v_r[4], v_r[9],  v_r[14]} <= g3;
        end
        step_r <= step_r + 5'd1;
        if (sts.comp_done) begin
          h_r[0] <= h_r[0] ^ g0[127:96] ^ g2[63:32];
          h_r[1] <= h_r[1] ^ g1[127:96] ^ g3[63:32];
          h_r[2] <= h_r[2] ^ g2[127:96] ^ g0[63:32];
          h_r[3] <= h_r[3] ^ g3[127:96] ^ g1[63:32];
          h_r[4] <= h_r[4] ^ g3[95:64] ^ g1[31:0];
          h_r[5] <= h_r[5] ^ g0[95:64] ^ g2[31:0];
          h_r[6] <= h_r[6] ^ g1[95:64] ^ g3[31:0];
          h_r[7] <= h_r[7] ^ g2[95:64] ^ g0[31:0];
        end
      end
      if (cmd.finish) begin
        nbuf_r <= '0;
      end
    end
  end
endmodule
`default_nettype wire
